// ----- sv/rsa_modexp_pkg.sv -----
// Package: fixed field widths, configuration register indexes and sequencer state codes for the modexp block.
`default_nettype none

package rsa_modexp_pkg;

   // Fixed widths of the channel fields and registers
   localparam int MSG_W     = 63;
   localparam int EXP_W     = 64;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_IDX_W = 1;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_EXPONENT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MODULUS  = 1'b1;

   // Control state codes of the exponent sequencer
   localparam int ST_W = 2;
   typedef logic [ST_W-1:0] state_type;
   localparam state_type ST_IDLE  = 2'd0;
   localparam state_type ST_ROUND = 2'd1;
   localparam state_type ST_WAIT  = 2'd2;
   localparam state_type ST_OUT   = 2'd3;

endpackage

`default_nettype wire

// ----- sv/rsa_modexp_mulmod.sv -----
// Bit-serial modular multiplier: interleaved shift-and-add with conditional subtract.
`default_nettype none

module rsa_modexp_mulmod #(
   parameter int WIDTH = 63
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [WIDTH-1:0] a_val,
   input  wire logic [WIDTH-1:0] b_val,
   input  wire logic [WIDTH-1:0] n_val,
   output logic                  done,
   output logic [WIDTH-1:0]      product
);

   localparam int CNT_W = $clog2(WIDTH);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [WIDTH-1:0] acc_ff, acc_in;
   logic [WIDTH-1:0] addend_ff, addend_in;
   logic [WIDTH-1:0] mult_ff, mult_in;
   logic [WIDTH-1:0] n_ff, n_in;

   logic [WIDTH:0]   sum;
   logic [WIDTH:0]   dbl;
   logic [WIDTH-1:0] acc_step;
   logic [WIDTH-1:0] addend_step;

   // One multiplier bit per cycle: add the addend, double it, reduce both
   always_comb begin
      sum = {1'b0, acc_ff} + (mult_ff[0] ? {1'b0, addend_ff} : '0);
      if (sum >= {1'b0, n_ff}) begin
         sum = sum - {1'b0, n_ff};
      end
      acc_step = sum[WIDTH-1:0];
      dbl = {addend_ff, 1'b0};
      if (dbl >= {1'b0, n_ff}) begin
         dbl = dbl - {1'b0, n_ff};
      end
      addend_step = dbl[WIDTH-1:0];
   end

   // Load operands on start, then step until every multiplier bit is used
   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      acc_in    = acc_ff;
      addend_in = addend_ff;
      mult_in   = mult_ff;
      n_in      = n_ff;
      if (start) begin
         busy_in   = 1'b1;
         cnt_in    = '0;
         acc_in    = '0;
         addend_in = a_val;
         mult_in   = b_val;
         n_in      = n_val;
      end else if (busy_ff) begin
         acc_in    = acc_step;
         addend_in = addend_step;
         mult_in   = mult_ff >> 1;
         cnt_in    = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff    <= cnt_in;
      acc_ff    <= acc_in;
      addend_ff <= addend_in;
      mult_ff   <= mult_in;
      n_ff      <= n_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

`default_nettype wire

// ----- sv/rsa_modular_exponentiation.sv -----
// Top level: right-to-left square-and-multiply modular exponentiation.
// Usage:
//   Write exponent (index 0) and modulus (index 1) on the csr_ port while idle;
//   a write takes effect at the clock edge where csr_wr_en is high.
//   Each req_ beat carries one message word and a final_word flag; each
//   beat yields exactly one rsp_ beat with power, range_error and final_out.
//   A message at or above the modulus returns range_error 1 and power 0;
//   it passes through ST_OUT into the rsp_ output register.
//   Otherwise each exponent bit up to the highest set one (up to 64 bits)
//   costs one round: two bit-serial modular multipliers (result*base and
//   base*base) run side by side, and ST_WAIT takes both products.
//   One item is worked on at a time; req_ready is high only while idle.
//   A finished result sits in the rsp_ output register; the next item may be
//   accepted while it waits, and a new result waits until the register frees.
//   Reset (synchronous, active high) sets exponent 1, modulus 3 and drops
//   any item in flight and any undelivered result.
`default_nettype none

module rsa_modular_exponentiation
   import rsa_modexp_pkg::*;
#(
   parameter int MOD_WIDTH = 63
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [MSG_W-1:0]      req_message,
   input  wire logic                  req_final_word,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [MSG_W-1:0]           rsp_power,
   output logic                       rsp_range_error,
   output logic                       rsp_final_out
);

   // Configuration registers
   logic [EXP_W-1:0]     exponent_ff;
   logic [MOD_WIDTH-1:0] modulus_ff;

   // Sequencer state
   state_type            state_ff, state_in;
   logic [EXP_W-1:0]     exp_ff, exp_in;
   logic [MOD_WIDTH-1:0] base_ff, base_in;
   logic [MOD_WIDTH-1:0] result_ff, result_in;
   logic                 err_ff, err_in;
   logic                 last_ff, last_in;

   // Output register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [MSG_W-1:0]     rsp_power_ff, rsp_power_in;
   logic                 rsp_err_ff, rsp_err_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 mm_start;
   logic                 mul_done, sq_done;
   logic [MOD_WIDTH-1:0] mul_prod, sq_prod;
   logic                 in_beat;
   logic                 out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign in_beat   = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign mm_start  = (state_ff == ST_ROUND) && (exp_ff != '0);

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         exponent_ff <= EXP_W'(1);
         modulus_ff  <= MOD_WIDTH'(3);
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_EXPONENT: exponent_ff <= csr_wdata;
            CSR_MODULUS:  modulus_ff  <= csr_wdata[MOD_WIDTH-1:0];
            default:      exponent_ff <= exponent_ff;
         endcase
      end
   end

   // Multiply unit: result * base
   rsa_modexp_mulmod #(
      .WIDTH (MOD_WIDTH)
   ) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mm_start),
      .a_val   (result_ff),
      .b_val   (base_ff),
      .n_val   (modulus_ff),
      .done    (mul_done),
      .product (mul_prod)
   );

   // Square unit: base * base
   rsa_modexp_mulmod #(
      .WIDTH (MOD_WIDTH)
   ) u_sq (
      .clock   (clock),
      .reset   (reset),
      .start   (mm_start),
      .a_val   (base_ff),
      .b_val   (base_ff),
      .n_val   (modulus_ff),
      .done    (sq_done),
      .product (sq_prod)
   );

   // Sequence exponent bits, one round per bit, lowest first
   always_comb begin
      state_in     = state_ff;
      exp_in       = exp_ff;
      base_in      = base_ff;
      result_in    = result_ff;
      err_in       = err_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_power_in = rsp_power_ff;
      rsp_err_in   = rsp_err_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (in_beat) begin
               last_in   = req_final_word;
               exp_in    = exponent_ff;
               base_in   = req_message[MOD_WIDTH-1:0];
               result_in = (modulus_ff > MOD_WIDTH'(1)) ? MOD_WIDTH'(1) : '0;
               if (req_message >= MSG_W'(modulus_ff)) begin
                  err_in    = 1'b1;
                  result_in = '0;
                  state_in  = ST_OUT;
               end else begin
                  err_in   = 1'b0;
                  state_in = ST_ROUND;
               end
            end
         end
         ST_ROUND: begin
            if (exp_ff == '0) begin
               state_in = ST_OUT;
            end else begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (mul_done && sq_done) begin
               if (exp_ff[0]) begin
                  result_in = mul_prod;
               end
               base_in  = sq_prod;
               exp_in   = exp_ff >> 1;
               state_in = ST_ROUND;
            end
         end
         ST_OUT: begin
            // Hold the result until the output register frees
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_power_in = MSG_W'(result_ff);
               rsp_err_in   = err_ff;
               rsp_last_in  = last_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      exp_ff       <= exp_in;
      base_ff      <= base_in;
      result_ff    <= result_in;
      err_ff       <= err_in;
      last_ff      <= last_in;
      rsp_power_ff <= rsp_power_in;
      rsp_err_ff   <= rsp_err_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_power       = rsp_power_ff;
   assign rsp_range_error = rsp_err_ff;
   assign rsp_final_out   = rsp_last_ff;

endmodule

`default_nettype wire

// ----- dv/rsa_modular_exponentiation_test.sv -----
// Self-checking testbench of the modular exponentiation block: directed table, then random phases.
module rsa_modular_exponentiation_test;
   import rsa_modexp_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int          HALF_PERIOD    = 4;
   localparam int          RESET_CYCLES   = 4;
   localparam int          LONG_HOLD      = 1500;
   localparam int          NUM_PHASES     = 14;
   localparam int          SMALL_ITEMS    = 9;
   localparam int          WIDE_ITEMS     = 4;
   localparam int          TAIL_CYCLES    = 4500;
   localparam int          END_WAIT_LIMIT = 200000;
   localparam logic [63:0] MOD_MASK       = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] ALL_ONES       = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [62:0] MSG_MAX        = 63'h7FFF_FFFF_FFFF_FFFF;

   // One expected result beat
   typedef struct {
      logic [MSG_W-1:0] power;
      logic             range_error;
      logic             last;
   } power_type;

   // One row of the directed table; typed rows carry their own expected result
   typedef struct {
      logic [63:0]      exponent;
      logic [63:0]      modulus;
      logic [MSG_W-1:0] message;
      logic             last;
      logic             typed;
      logic [MSG_W-1:0] power;
      logic             range_error;
   } word_row_type;

   localparam int NUM_DIRECTED = 21;

   word_row_type directed_rows [NUM_DIRECTED] = '{
      // reset settings: exponent 1, modulus 3
      '{64'd1, 64'd3, 63'd0, 1'b0, 1'b1, 63'd0, 1'b0},
      '{64'd1, 64'd3, 63'd2, 1'b1, 1'b1, 63'd2, 1'b0},
      '{64'd1, 64'd3, 63'd3, 1'b0, 1'b1, 63'd0, 1'b1},
      '{64'd1, 64'd3, MSG_MAX, 1'b1, 1'b1, 63'd0, 1'b1},
      // exponent zero gives one, largest modulus
      '{64'd0, MOD_MASK, 63'd0, 1'b0, 1'b1, 63'd1, 1'b0},
      '{64'd0, MOD_MASK, MSG_MAX - 63'd1, 1'b1, 1'b1, 63'd1, 1'b0},
      '{64'd0, MOD_MASK, MSG_MAX, 1'b0, 1'b1, 63'd0, 1'b1},
      // modulus one: only message zero is in range, result zero
      '{64'd0, 64'd1, 63'd0, 1'b0, 1'b1, 63'd0, 1'b0},
      '{64'd0, 64'd1, 63'd1, 1'b1, 1'b1, 63'd0, 1'b1},
      // modulus zero: every message out of range
      '{64'd5, 64'd0, 63'd0, 1'b0, 1'b1, 63'd0, 1'b1},
      '{64'd5, 64'd0, 63'h2A5, 1'b1, 1'b1, 63'd0, 1'b1},
      // modulus two
      '{64'd5, 64'd2, 63'd1, 1'b0, 1'b1, 63'd1, 1'b0},
      '{64'd5, 64'd2, 63'd0, 1'b1, 1'b1, 63'd0, 1'b0},
      '{64'd5, 64'd2, 63'd2, 1'b0, 1'b1, 63'd0, 1'b1},
      // full-width exponent; modulus write with bit 63 set is masked down
      '{ALL_ONES, ALL_ONES, MSG_MAX - 63'd1, 1'b0, 1'b1, MSG_MAX - 63'd1, 1'b0},
      '{ALL_ONES, ALL_ONES, 63'd1, 1'b1, 1'b1, 63'd1, 1'b0},
      '{ALL_ONES, ALL_ONES, 63'h5555_5555_5555_5555, 1'b0, 1'b0, 63'd0, 1'b0},
      // predicted rows
      '{64'd2, 64'h7FFF_FFFF_FFFF_FFE7, 63'h1234_5678_9ABC_DEF0, 1'b1, 1'b0, 63'd0, 1'b0},
      '{64'd65537, 64'hC5F1_3A1B, 63'h9ABC, 1'b0, 1'b0, 63'd0, 1'b0},
      '{64'd65537, 64'hC5F1_3A1B, 63'hC5F1_3A1A, 1'b1, 1'b0, 63'd0, 1'b0},
      '{64'h8000_0000_0000_0000, 64'd1000003, 63'd2, 1'b0, 1'b0, 63'd0, 1'b0}
   };

   logic                  clock           = 1'b0;
   logic                  reset           = 1'b1;
   logic                  csr_wr_en       = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index       = CSR_EXPONENT;
   logic [CSR_DATA_W-1:0] csr_wdata       = '0;
   logic                  req_valid       = 1'b0;
   logic                  req_ready;
   logic [MSG_W-1:0]      req_message     = '0;
   logic                  req_final_word  = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready       = 1'b0;
   logic [MSG_W-1:0]      rsp_power;
   logic                  rsp_range_error;
   logic                  rsp_final_out;

   // Predictor's copy of the registers
   logic [63:0] exponent_reg = 64'd1;
   logic [63:0] modulus_reg  = 64'd3;
   logic [63:0] exponent_raw = 64'd1;
   logic [63:0] modulus_raw  = 64'd3;

   power_type powers_due [$];
   int     mismatches     = 0;
   int     words_sent     = 0;
   int     powers_checked = 0;
   int     range_errors   = 0;
   int     settings_used  = 0;
   int     wide_words     = 0;
   logic   no_idle        = 1'b0;
   int     hold_asks      = 0;
   int     hold_seen      = 0;
   int     hold_left      = 0;
   int     stall_left     = 0;

   rsa_modular_exponentiation dut (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_message     (req_message),
      .req_final_word  (req_final_word),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_power       (rsp_power),
      .rsp_range_error (rsp_range_error),
      .rsp_final_out   (rsp_final_out)
   );

   always #HALF_PERIOD clock = ~clock;

   // Hang guard
   initial begin
      #6_000_000;
      $display("simulation failed");
      $finish;
   end

   // Bit-serial a*b mod n, all operands below n
   function automatic logic [63:0] mul_reduce(input logic [63:0] a, input logic [63:0] b,
                                              input logic [63:0] n);
      logic [63:0] acc;
      logic [63:0] addend;
      logic [63:0] mult;
      acc    = '0;
      addend = a;
      mult   = b;
      while (mult != 0) begin
         if (mult[0]) begin
            acc = acc + addend;
            if (acc >= n) acc = acc - n;
         end
         addend = addend << 1;
         if (addend >= n) addend = addend - n;
         mult = mult >> 1;
      end
      return acc;
   endfunction

   // Right-to-left square-and-multiply
   function automatic logic [63:0] power_reduce(input logic [63:0] base, input logic [63:0] e,
                                                input logic [63:0] n);
      logic [63:0] acc;
      logic [63:0] sq;
      acc = (n > 64'd1) ? 64'd1 : 64'd0;
      sq  = base;
      for (int i = 0; i < 64; i++) begin
         if (e[i]) acc = mul_reduce(acc, sq, n);
         sq = mul_reduce(sq, sq, n);
      end
      return acc;
   endfunction

   function automatic power_type predict_power(input logic [MSG_W-1:0] msg, input logic last);
      power_type   res;
      logic [63:0] m;
      m               = {1'b0, msg};
      res.last        = last;
      res.range_error = (m >= modulus_reg);
      res.power       = '0;
      if (!res.range_error) res.power = MSG_W'(power_reduce(m, exponent_reg, modulus_reg));
      return res;
   endfunction

   // Mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   // Offer one message beat and return at the edge where it is taken
   task automatic offer_word(input logic [MSG_W-1:0] msg, input logic last);
      int gap;
      gap = no_idle ? 0 : pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_message    <= msg;
      req_final_word <= last;
      do @(posedge clock); while (!req_ready);
      words_sent++;
   endtask

   // Drop valid and wait until every pending power has come back
   task automatic drain_powers();
      req_valid <= 1'b0;
      while (powers_due.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // Write both registers while idle
   task automatic apply_settings(input logic [63:0] e, input logic [63:0] n);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_EXPONENT;
      csr_wdata <= e;
      @(posedge clock);
      csr_index <= CSR_MODULUS;
      csr_wdata <= n;
      @(posedge clock);
      csr_wr_en    <= 1'b0;
      exponent_raw  = e;
      modulus_raw   = n;
      exponent_reg  = e;
      modulus_reg   = n & MOD_MASK;
      settings_used++;
      @(posedge clock);
   endtask

   // Receiver: random stalls, long hold on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_asks != hold_seen) begin
         hold_seen <= hold_asks;
         hold_left <= LONG_HOLD;
         rsp_ready <= 1'b0;
      end else if (stall_left != 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (no_idle || $urandom_range(0, 3) != 0) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready  <= 1'b0;
         stall_left <= pick_gap();
      end
   end

   // Compare each result beat with the oldest pending power
   always @(posedge clock) begin
      power_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (powers_due.size() == 0) begin
            $error("result beat with nothing pending: power %h", rsp_power);
            mismatches++;
         end else begin
            want = powers_due.pop_front();
            powers_checked++;
            if (rsp_range_error) range_errors++;
            if (rsp_power !== want.power) begin
               $error("power: expected %h, got %h", want.power, rsp_power);
               mismatches++;
            end
            if (rsp_range_error !== want.range_error) begin
               $error("range_error: expected %b, got %b", want.range_error, rsp_range_error);
               mismatches++;
            end
            if (rsp_final_out !== want.last) begin
               $error("final_out: expected %b, got %b", want.last, rsp_final_out);
               mismatches++;
            end
         end
      end
   end

   // Stimulus
   initial begin
      word_row_type row;
      power_type    due;
      logic [63:0] e;
      logic [63:0] n;
      logic [63:0] n63;
      logic [63:0] wide;
      logic [MSG_W-1:0] msg;
      int          items;
      int          bits;
      int          pick;
      int          waited;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table; settings change only between drained groups
      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.exponent != exponent_raw || row.modulus != modulus_raw) begin
            drain_powers();
            apply_settings(row.exponent, row.modulus);
         end
         if (exponent_reg[63]) wide_words++;
         offer_word(row.message, row.last);
         if (row.typed) begin
            due.power       = row.power;
            due.range_error = row.range_error;
            due.last        = row.last;
         end else begin
            due = predict_power(row.message, row.last);
         end
         powers_due.push_back(due);
      end

      // Random phases: mostly short exponents, two full-width ones
      for (int p = 0; p < NUM_PHASES; p++) begin
         drain_powers();
         if (p == 4) begin
            e = ALL_ONES;
         end else if (p == 10) begin
            e = {1'b1, 31'($urandom), 32'($urandom)};
         end else begin
            bits = $urandom_range(0, 8);
            e    = {32'($urandom), 32'($urandom)} & ((64'd1 << bits) - 64'd1);
         end
         wide = {32'($urandom), 32'($urandom)};
         case (p % 4)
            0: n63 = {2'b01, wide[61:0]};
            1: n63 = 64'($urandom_range(3, 5000));
            2: n63 = (wide & MOD_MASK) >> $urandom_range(0, 59);
            default: n63 = MOD_MASK;
         endcase
         if (n63 < 64'd3) n63 = 64'd3;
         // bit 63 of the write is dropped by the block
         n = {1'($urandom_range(0, 1)), n63[62:0]};
         apply_settings(e, n);
         no_idle <= (p % 5 == 1);
         if (p == 2 || p == 8) hold_asks <= hold_asks + 1;
         items = (p == 4 || p == 10) ? WIDE_ITEMS : SMALL_ITEMS;
         for (int k = 0; k < items; k++) begin
            wide = {32'($urandom), 32'($urandom)};
            pick = $urandom_range(0, 19);
            if (pick < 15) msg = MSG_W'(wide % modulus_reg);
            else if (pick == 15) msg = '0;
            else if (pick == 16) msg = MSG_W'(modulus_reg - 64'd1);
            else if (pick == 17) msg = MSG_W'(modulus_reg);
            else msg = wide[MSG_W-1:0];
            if (exponent_reg[63]) wide_words++;
            offer_word(msg, 1'($urandom_range(0, 1)));
            powers_due.push_back(predict_power(msg, req_final_word));
         end
      end

      // Wind down
      req_valid <= 1'b0;
      waited = 0;
      while (powers_due.size() != 0 && waited < END_WAIT_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      while (powers_due.size() != 0) begin
         due = powers_due.pop_front();
         $error("power %h never delivered", due.power);
         mismatches++;
      end

      $display("%0d words offered under %0d register settings, %0d with a full-width exponent",
               words_sent, settings_used, wide_words);
      $display("%0d powers checked, %0d of them out of range, %0d mismatches",
               powers_checked, range_errors, mismatches);
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
